### hw/rtl/tbld_pkg.sv
`default_nettype none

package tbld_pkg;

  localparam int NUM_COLORS = 11;
  localparam int CI_W       = 4;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_PRESS,
    PH_RAMP,
    PH_FLASH,
    PH_RELEASE,
    PH_DEBOUNCE,
    PH_REPEAT
  } phase_t;

  // register index = paddr[4:2]
  typedef enum logic [2:0] {
    REG_LONG_PRESS,
    REG_RAMP_STEP,
    REG_FLASH,
    REG_COLOR_REPEAT,
    REG_DEBOUNCE,
    REG_MIN_BRIGHT,
    REG_MAX_BRIGHT
  } reg_idx_t;

  localparam logic [7:0] FLASH_MAX_LEVEL = 8'd10;
  localparam logic [7:0] FLASH_MIN_LEVEL = 8'd200;
  localparam logic [7:0] RESET_LEVEL     = 8'd25;

  localparam logic [15:0] RST_LONG_PRESS   = 16'd1000;
  localparam logic [7:0]  RST_RAMP_STEP    = 8'd10;
  localparam logic [9:0]  RST_FLASH        = 10'd50;
  localparam logic [11:0] RST_COLOR_REPEAT = 12'd500;
  localparam logic [7:0]  RST_DEBOUNCE     = 8'd10;
  localparam logic [7:0]  RST_MIN_BRIGHT   = 8'd20;
  localparam logic [7:0]  RST_MAX_BRIGHT   = 8'd255;

  typedef struct packed {
    logic power_button;
    logic color_button;
  } tick_t;

  typedef struct packed {
    logic            lamp_lit;
    logic            indicator_led;
    logic [7:0]      shown_brightness;
    logic [7:0]      red_level;
    logic [7:0]      green_level;
    logic [7:0]      blue_level;
    logic [7:0]      white_level;
    logic [CI_W-1:0] color_number;
  } result_t;

  typedef struct packed {
    logic [15:0] long_press_ticks;
    logic [7:0]  ramp_step_ticks;
    logic [9:0]  flash_ticks;
    logic [11:0] color_repeat_ticks;
    logic [7:0]  debounce_ticks;
    logic [7:0]  min_bright;
    logic [7:0]  max_bright;
  } cfg_t;

  typedef struct packed {
    logic            lit;
    logic [7:0]      shown;
    logic [CI_W-1:0] color;
  } lamp_state_t;

  // {red, green, blue, white}; out-of-range index shows white only
  function automatic logic [31:0] color_rgbw(input logic [CI_W-1:0] idx);
    logic [31:0] c;
    case (idx)
      4'd1:    c = {8'd255, 8'd0,   8'd0,   8'd0};
      4'd2:    c = {8'd255, 8'd255, 8'd0,   8'd0};
      4'd3:    c = {8'd0,   8'd255, 8'd0,   8'd0};
      4'd4:    c = {8'd0,   8'd255, 8'd255, 8'd0};
      4'd5:    c = {8'd0,   8'd0,   8'd255, 8'd0};
      4'd6:    c = {8'd255, 8'd0,   8'd255, 8'd0};
      4'd7:    c = {8'd255, 8'd0,   8'd0,   8'd255};
      4'd8:    c = {8'd0,   8'd255, 8'd0,   8'd255};
      4'd9:    c = {8'd0,   8'd0,   8'd255, 8'd255};
      4'd10:   c = {8'd255, 8'd255, 8'd255, 8'd255};
      default: c = {8'd0,   8'd0,   8'd0,   8'd255};
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/tbld_cfg.sv
`default_nettype none

module tbld_cfg import tbld_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg
);

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[4:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.long_press_ticks   <= RST_LONG_PRESS;
      cfg.ramp_step_ticks    <= RST_RAMP_STEP;
      cfg.flash_ticks        <= RST_FLASH;
      cfg.color_repeat_ticks <= RST_COLOR_REPEAT;
      cfg.debounce_ticks     <= RST_DEBOUNCE;
      cfg.min_bright         <= RST_MIN_BRIGHT;
      cfg.max_bright         <= RST_MAX_BRIGHT;
    end else if (wr) begin
      unique case (idx)
        REG_LONG_PRESS:   cfg.long_press_ticks   <= pwdata[15:0];
        REG_RAMP_STEP:    cfg.ramp_step_ticks    <= pwdata[7:0];
        REG_FLASH:        cfg.flash_ticks        <= pwdata[9:0];
        REG_COLOR_REPEAT: cfg.color_repeat_ticks <= pwdata[11:0];
        REG_DEBOUNCE:     cfg.debounce_ticks     <= pwdata[7:0];
        REG_MIN_BRIGHT:   cfg.min_bright         <= pwdata[7:0];
        REG_MAX_BRIGHT:   cfg.max_bright         <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_LONG_PRESS:   prdata = {16'd0, cfg.long_press_ticks};
      REG_RAMP_STEP:    prdata = {24'd0, cfg.ramp_step_ticks};
      REG_FLASH:        prdata = {22'd0, cfg.flash_ticks};
      REG_COLOR_REPEAT: prdata = {20'd0, cfg.color_repeat_ticks};
      REG_DEBOUNCE:     prdata = {24'd0, cfg.debounce_ticks};
      REG_MIN_BRIGHT:   prdata = {24'd0, cfg.min_bright};
      REG_MAX_BRIGHT:   prdata = {24'd0, cfg.max_bright};
      default:          prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/tbld_fsm.sv
`default_nettype none

module tbld_fsm import tbld_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  acc,
  input  wire tick_t tick,
  input  wire cfg_t  cfg,
  output lamp_state_t st_next
);

  phase_t          phase, phase_next;
  logic [15:0]     tmr, tmr_next;
  logic            lit, lit_next;
  logic [CI_W-1:0] ci, ci_next;
  logic [7:0]      lvl, lvl_next;
  logic            dn, dn_next;
  logic            fam, fam_next;

  logic [15:0]       tmr_inc;
  logic [15:0]       long_per;
  logic [7:0]        ramp_per;
  logic [11:0]       rep_per;
  logic              dir_fix, rdir;
  logic signed [9:0] v;
  logic              v_hi, v_lo;
  phase_t            r_phase;
  logic [7:0]        r_lvl;
  logic              r_dn, r_fam;
  logic [CI_W-1:0]   ci_inc;
  logic              p1, p2;

  assign p1 = tick.power_button;
  assign p2 = tick.color_button;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      tmr   <= '0;
      lit   <= 1'b0;
      ci    <= '0;
      lvl   <= RESET_LEVEL;
      dn    <= 1'b0;
      fam   <= 1'b0;
    end else if (acc) begin
      phase <= phase_next;
      tmr   <= tmr_next;
      lit   <= lit_next;
      ci    <= ci_next;
      lvl   <= lvl_next;
      dn    <= dn_next;
      fam   <= fam_next;
    end
  end

  // one ramp step, shared by the long-press and ramp phases
  always_comb begin
    tmr_inc  = (tmr == 16'hFFFF) ? tmr : tmr + 16'd1;
    long_per = (cfg.long_press_ticks == '0) ? 16'd1 : cfg.long_press_ticks;
    ramp_per = (cfg.ramp_step_ticks == '0) ? 8'd1 : cfg.ramp_step_ticks;
    rep_per  = (cfg.color_repeat_ticks == '0) ? 12'd1 : cfg.color_repeat_ticks;
    ci_inc   = (ci >= CI_W'(NUM_COLORS - 1)) ? '0 : ci + 1'b1;

    dir_fix = !dn;
    if (!dir_fix && lvl >= cfg.max_bright) begin
      dir_fix = 1'b1;
    end else if (dir_fix && lvl <= cfg.min_bright) begin
      dir_fix = 1'b0;
    end
    rdir = (phase == PH_PRESS) ? dir_fix : dn;

    v    = $signed({2'b00, lvl}) + (rdir ? -10'sd1 : 10'sd1);
    v_hi = v >= $signed({2'b00, cfg.max_bright});
    v_lo = v <= $signed({2'b00, cfg.min_bright});

    r_phase = PH_RAMP;
    r_lvl   = v[7:0];
    r_dn    = rdir;
    r_fam   = fam;
    if (v_hi) begin
      r_lvl = cfg.max_bright;
      r_dn  = 1'b1;
      r_fam = 1'b1;
    end else if (v_lo) begin
      r_lvl = cfg.min_bright;
      r_dn  = 1'b0;
      r_fam = 1'b0;
    end
    if (v_hi || v_lo) begin
      r_phase = (cfg.flash_ticks == '0) ? PH_RELEASE : PH_FLASH;
    end
  end

  always_comb begin
    phase_next = phase;
    tmr_next   = tmr;
    lit_next   = lit;
    ci_next    = ci;
    lvl_next   = lvl;
    dn_next    = dn;
    fam_next   = fam;
    unique case (phase)
      PH_IDLE: begin
        if (p1) begin
          phase_next = PH_PRESS;
          tmr_next   = '0;
        end else if (p2 && lit) begin
          phase_next = PH_DEBOUNCE;
          tmr_next   = '0;
          if (cfg.debounce_ticks == '0) begin
            ci_next    = ci_inc;
            phase_next = PH_REPEAT;
          end
        end
      end
      PH_PRESS: begin
        if (!p1) begin
          lit_next   = !lit;
          phase_next = PH_IDLE;
        end else begin
          tmr_next = tmr_inc;
          if (tmr_inc >= long_per) begin
            lit_next   = 1'b1;
            tmr_next   = '0;
            phase_next = r_phase;
            lvl_next   = r_lvl;
            dn_next    = r_dn;
            fam_next   = r_fam;
          end
        end
      end
      PH_RAMP: begin
        if (!p1) begin
          phase_next = PH_IDLE;
        end else begin
          tmr_next = tmr_inc;
          if (tmr_inc >= {8'd0, ramp_per}) begin
            tmr_next   = '0;
            phase_next = r_phase;
            lvl_next   = r_lvl;
            dn_next    = r_dn;
            fam_next   = r_fam;
          end
        end
      end
      PH_FLASH: begin
        tmr_next = tmr_inc;
        if (tmr_inc >= {6'd0, cfg.flash_ticks}) begin
          phase_next = p1 ? PH_RELEASE : PH_IDLE;
        end
      end
      PH_RELEASE: begin
        if (!p1) phase_next = PH_IDLE;
      end
      PH_DEBOUNCE: begin
        tmr_next = tmr_inc;
        if (tmr_inc >= {8'd0, cfg.debounce_ticks}) begin
          if (p2) begin
            ci_next    = ci_inc;
            tmr_next   = '0;
            phase_next = PH_REPEAT;
          end else begin
            phase_next = PH_IDLE;
          end
        end
      end
      PH_REPEAT: begin
        tmr_next = tmr_inc;
        if (tmr_inc >= {4'd0, rep_per}) begin
          if (p2) begin
            ci_next  = ci_inc;
            tmr_next = '0;
          end else begin
            phase_next = PH_IDLE;
          end
        end
      end
      default: phase_next = PH_IDLE;
    endcase

    st_next.lit   = lit_next;
    st_next.color = ci_next;
    if (phase_next == PH_FLASH) begin
      st_next.shown = fam_next ? FLASH_MAX_LEVEL : FLASH_MIN_LEVEL;
    end else begin
      st_next.shown = lvl_next;
    end
  end

  // the limit flash always leaves the direction pointing away from that limit
  a_flash_dir: assert property (@(posedge clk) disable iff (rst)
    phase == PH_FLASH |-> dn == fam)
    else $error("flash limit and ramp direction disagree");

  a_idle_press: assert property (@(posedge clk) disable iff (rst)
    acc && phase == PH_IDLE && p1 |=> phase == PH_PRESS && tmr == '0)
    else $error("power press from idle not taken");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !acc |=> $stable(phase) && $stable(lvl) && $stable(ci) && $stable(lit))
    else $error("state moved without an item");

endmodule

`default_nettype wire

### hw/rtl/tbld_out.sv
`default_nettype none

module tbld_out import tbld_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        load,
  input  wire lamp_state_t st,
  input  wire logic        result_stall,
  output logic             result_valid,
  output result_t          result
);

  result_t     res_d;
  logic [31:0] rgbw;

  always_comb begin
    rgbw                   = st.lit ? color_rgbw(st.color) : 32'd0;
    res_d.lamp_lit         = st.lit;
    res_d.indicator_led    = st.lit;
    res_d.shown_brightness = st.shown;
    res_d.red_level        = rgbw[31:24];
    res_d.green_level      = rgbw[23:16];
    res_d.blue_level       = rgbw[15:8];
    res_d.white_level      = rgbw[7:0];
    res_d.color_number     = st.color;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) result <= res_d;
  end

endmodule

`default_nettype wire

### hw/rtl/two_button_lamp_dimmer.sv
// Latency: the result of an item is valid in the cycle after the item is accepted.
// Throughput: one item per cycle; the only limit is the single output register,
// which can take a new item in the same cycle its old one is taken.
// Reset (rst, synchronous): lamp off, idle, level 25, color 0, output empty,
// registers back to their default timings and brightness limits.
`default_nettype none

module two_button_lamp_dimmer import tbld_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        tick_valid,
  output logic             tick_stall,
  input  wire tick_t       tick,
  output logic             result_valid,
  input  wire logic        result_stall,
  output result_t          result,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t        cfg;
  lamp_state_t st_next;
  logic        acc;

  assign tick_stall = result_valid && result_stall;
  assign acc        = tick_valid && !tick_stall;

  tbld_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tbld_fsm u_fsm (
    .clk     (clk),
    .rst     (rst),
    .acc     (acc),
    .tick    (tick),
    .cfg     (cfg),
    .st_next (st_next)
  );

  tbld_out u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (acc),
    .st           (st_next),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

`default_nettype wire

### sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import tbld_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_OFF    = 300;
  localparam int PHASE_ITEMS = 80;

  typedef enum logic [1:0] {
    ROW_TICK,
    ROW_CHECK,
    ROW_REG
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    reg_idx_t    idx;
    logic [31:0] value;
    tick_t       t;
    result_t     want;
  } dir_row_t;

  typedef struct packed {
    tick_t   t;
    logic    known;
    result_t want;
  } button_item_t;

  typedef struct packed {
    result_t lamp;
    logic    known;
    result_t want;
  } lamp_expect_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        tick_valid = 1'b0;
  logic        tick_stall;
  tick_t       tick = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  result_t     result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  two_button_lamp_dimmer dut (
    .clk          (clk),
    .rst          (rst),
    .tick_valid   (tick_valid),
    .tick_stall   (tick_stall),
    .tick         (tick),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // {red, green, blue, white} per color number
  logic [31:0] rgbw_tab [11] = '{
    32'h000000FF, 32'hFF000000, 32'hFFFF0000, 32'h00FF0000,
    32'h00FFFF00, 32'h0000FF00, 32'hFF00FF00, 32'hFF0000FF,
    32'h00FF00FF, 32'h0000FFFF, 32'hFFFFFFFF
  };

  // tick column is {power, color}
  dir_row_t dir_tab [29] = '{
    '{ROW_CHECK, REG_LONG_PRESS, 32'd0, 2'b00, '{1'b0, 1'b0, 8'd25, 8'd0, 8'd0, 8'd0, 8'd0, 4'd0}},
    '{ROW_CHECK, REG_LONG_PRESS, 32'd0, 2'b01, '{1'b0, 1'b0, 8'd25, 8'd0, 8'd0, 8'd0, 8'd0, 4'd0}},
    '{ROW_CHECK, REG_LONG_PRESS, 32'd0, 2'b10, '{1'b0, 1'b0, 8'd25, 8'd0, 8'd0, 8'd0, 8'd0, 4'd0}},
    '{ROW_CHECK, REG_LONG_PRESS, 32'd0, 2'b00,
      '{1'b1, 1'b1, 8'd25, 8'd0, 8'd0, 8'd0, 8'd255, 4'd0}},
    '{ROW_TICK,  REG_LONG_PRESS, 32'd0, 2'b11, '0},
    '{ROW_CHECK, REG_LONG_PRESS, 32'd0, 2'b00, '{1'b0, 1'b0, 8'd25, 8'd0, 8'd0, 8'd0, 8'd0, 4'd0}},
    '{ROW_REG,   REG_LONG_PRESS,   32'd2,  2'b00, '0},
    '{ROW_REG,   REG_RAMP_STEP,    32'd1,  2'b00, '0},
    '{ROW_REG,   REG_FLASH,        32'd1,  2'b00, '0},
    '{ROW_REG,   REG_COLOR_REPEAT, 32'd1,  2'b00, '0},
    '{ROW_REG,   REG_DEBOUNCE,     32'd0,  2'b00, '0},
    '{ROW_REG,   REG_MIN_BRIGHT,   32'd24, 2'b00, '0},
    '{ROW_REG,   REG_MAX_BRIGHT,   32'd27, 2'b00, '0},
    '{ROW_TICK,  REG_LONG_PRESS, 32'd0, 2'b10, '0},
    '{ROW_TICK,  REG_LONG_PRESS, 32'd0, 2'b10, '0},
    // long press on dark lamp steps straight into the min limit
    '{ROW_CHECK, REG_LONG_PRESS, 32'd0, 2'b10,
      '{1'b1, 1'b1, 8'd200, 8'd0, 8'd0, 8'd0, 8'd255, 4'd0}},
    '{ROW_TICK,  REG_LONG_PRESS, 32'd0, 2'b10, '0},
    '{ROW_TICK,  REG_LONG_PRESS, 32'd0, 2'b00, '0},
    '{ROW_TICK,  REG_LONG_PRESS, 32'd0, 2'b10, '0},
    '{ROW_TICK,  REG_LONG_PRESS, 32'd0, 2'b10, '0},
    // direction corrected at min, ramps up to the max flash
    '{ROW_TICK,  REG_LONG_PRESS, 32'd0, 2'b10, '0},
    '{ROW_TICK,  REG_LONG_PRESS, 32'd0, 2'b10, '0},
    '{ROW_CHECK, REG_LONG_PRESS, 32'd0, 2'b10,
      '{1'b1, 1'b1, 8'd10, 8'd0, 8'd0, 8'd0, 8'd255, 4'd0}},
    '{ROW_TICK,  REG_LONG_PRESS, 32'd0, 2'b00, '0},
    '{ROW_TICK,  REG_LONG_PRESS, 32'd0, 2'b01, '0},
    '{ROW_TICK,  REG_LONG_PRESS, 32'd0, 2'b01, '0},
    '{ROW_TICK,  REG_LONG_PRESS, 32'd0, 2'b10, '0},
    '{ROW_TICK,  REG_LONG_PRESS, 32'd0, 2'b10, '0},
    '{ROW_CHECK, REG_LONG_PRESS, 32'd0, 2'b00, '{1'b0, 1'b0, 8'd27, 8'd0, 8'd0, 8'd0, 8'd0, 4'd2}}
  };

  // predictor state and register copy
  cfg_t        lamp_cfg;
  phase_t      lamp_phase;
  logic [15:0] lamp_timer;
  logic        lamp_on;
  logic        ramp_dn;
  logic        flash_max;
  logic [3:0]  color_idx;
  logic [7:0]  bright;

  button_item_t button_q [$];
  lamp_expect_t lamp_expect_q [$];
  button_item_t on_bus;
  lamp_expect_t head;
  int           queued_items = 0;
  int           fail_count = 0;
  int           tx_idle_pct = 0;
  int           rx_stall_pct = 0;
  int           rx_hold_reqs = 0;
  int           rx_hold_seen = 0;
  int           rx_hold_left = 0;
  int           quiet_cycles = 0;

  function automatic logic [15:0] at_least_one(input logic [15:0] p);
    return (p == 16'd0) ? 16'd1 : p;
  endfunction

  function automatic void lamp_reset();
    lamp_cfg   = '{RST_LONG_PRESS, RST_RAMP_STEP, RST_FLASH, RST_COLOR_REPEAT,
                   RST_DEBOUNCE, RST_MIN_BRIGHT, RST_MAX_BRIGHT};
    lamp_phase = PH_IDLE;
    lamp_timer = '0;
    lamp_on    = 1'b0;
    ramp_dn    = 1'b0;
    flash_max  = 1'b0;
    color_idx  = '0;
    bright     = RESET_LEVEL;
  endfunction

  function automatic void timer_inc();
    if (lamp_timer != 16'hFFFF) lamp_timer++;
  endfunction

  function automatic void color_advance();
    color_idx++;
    if (color_idx >= NUM_COLORS) color_idx = '0;
  endfunction

  function automatic void ramp_once();
    int v;
    v = int'(bright) + (ramp_dn ? -1 : 1);
    lamp_timer = '0;
    lamp_phase = PH_RAMP;
    // max limit wins when both hold
    if (v >= int'(lamp_cfg.max_bright)) begin
      bright     = lamp_cfg.max_bright;
      ramp_dn    = 1'b1;
      flash_max  = 1'b1;
      lamp_phase = PH_FLASH;
    end else if (v <= int'(lamp_cfg.min_bright)) begin
      bright     = lamp_cfg.min_bright;
      ramp_dn    = 1'b0;
      flash_max  = 1'b0;
      lamp_phase = PH_FLASH;
    end else begin
      bright = v[7:0];
    end
    if (lamp_phase == PH_FLASH && lamp_cfg.flash_ticks == '0) lamp_phase = PH_RELEASE;
  endfunction

  function automatic void debounce_done(input logic held);
    if (lamp_timer >= lamp_cfg.debounce_ticks) begin
      if (held) begin
        color_advance();
        lamp_timer = '0;
        lamp_phase = PH_REPEAT;
      end else begin
        lamp_phase = PH_IDLE;
      end
    end
  endfunction

  function automatic result_t lamp_step(input tick_t t);
    result_t r;
    case (lamp_phase)
      PH_IDLE: begin
        if (t.power_button) begin
          lamp_phase = PH_PRESS;
          lamp_timer = '0;
        end else if (t.color_button && lamp_on) begin
          lamp_phase = PH_DEBOUNCE;
          lamp_timer = '0;
          debounce_done(t.color_button);
        end
      end
      PH_PRESS: begin
        if (!t.power_button) begin
          lamp_on    = ~lamp_on;
          lamp_phase = PH_IDLE;
        end else begin
          timer_inc();
          if (lamp_timer >= at_least_one(lamp_cfg.long_press_ticks)) begin
            lamp_on = 1'b1;
            ramp_dn = ~ramp_dn;
            if (!ramp_dn && bright >= lamp_cfg.max_bright) ramp_dn = 1'b1;
            else if (ramp_dn && bright <= lamp_cfg.min_bright) ramp_dn = 1'b0;
            ramp_once();
          end
        end
      end
      PH_RAMP: begin
        if (!t.power_button) begin
          lamp_phase = PH_IDLE;
        end else begin
          timer_inc();
          if (lamp_timer >= at_least_one({8'd0, lamp_cfg.ramp_step_ticks})) ramp_once();
        end
      end
      PH_FLASH: begin
        timer_inc();
        if (lamp_timer >= lamp_cfg.flash_ticks)
          lamp_phase = t.power_button ? PH_RELEASE : PH_IDLE;
      end
      PH_RELEASE: begin
        if (!t.power_button) lamp_phase = PH_IDLE;
      end
      PH_DEBOUNCE: begin
        timer_inc();
        debounce_done(t.color_button);
      end
      PH_REPEAT: begin
        timer_inc();
        if (lamp_timer >= at_least_one({4'd0, lamp_cfg.color_repeat_ticks})) begin
          if (t.color_button) begin
            color_advance();
            lamp_timer = '0;
          end else begin
            lamp_phase = PH_IDLE;
          end
        end
      end
      default: lamp_phase = PH_IDLE;
    endcase
    r.lamp_lit         = lamp_on;
    r.indicator_led    = lamp_on;
    r.shown_brightness = (lamp_phase == PH_FLASH) ?
                         (flash_max ? FLASH_MAX_LEVEL : FLASH_MIN_LEVEL) : bright;
    {r.red_level, r.green_level, r.blue_level, r.white_level} =
      !lamp_on ? 32'd0 : (color_idx < NUM_COLORS) ? rgbw_tab[color_idx] : rgbw_tab[0];
    r.color_number = color_idx;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  task automatic compare_result(input result_t want, input result_t got);
    check_field("lamp_lit", 8'(want.lamp_lit), 8'(got.lamp_lit));
    check_field("indicator_led", 8'(want.indicator_led), 8'(got.indicator_led));
    check_field("shown_brightness", want.shown_brightness, got.shown_brightness);
    check_field("red_level", want.red_level, got.red_level);
    check_field("green_level", want.green_level, got.green_level);
    check_field("blue_level", want.blue_level, got.blue_level);
    check_field("white_level", want.white_level, got.white_level);
    check_field("color_number", 8'(want.color_number), 8'(got.color_number));
  endtask

  function automatic void queue_tick(input logic pw, input logic co);
    button_item_t it;
    it = '0;
    it.t.power_button = pw;
    it.t.color_button = co;
    button_q.push_back(it);
    queued_items++;
  endfunction

  // one power press or hold, a color hold, a burst of noise or nothing, then a short release
  function automatic void add_gesture();
    int kind, len, steps, lp;
    kind = $urandom_range(99);
    lp   = int'(at_least_one(lamp_cfg.long_press_ticks));
    if (kind < 50) begin
      if (kind < 30) begin
        steps = ($urandom_range(3) == 0) ? $urandom_range(280) : $urandom_range(40);
        len = lp + int'(lamp_cfg.flash_ticks) + $urandom_range(2) +
              steps * int'(at_least_one({8'd0, lamp_cfg.ramp_step_ticks}));
        if (len > 300) len = $urandom_range(1, 300);
      end else begin
        len = $urandom_range(1, (lp + 1 > 300) ? 300 : lp + 1);
      end
      for (int i = 0; i < len; i++) queue_tick(1'b1, $urandom_range(4) == 0);
    end else if (kind < 75) begin
      len = int'(lamp_cfg.debounce_ticks) +
            $urandom_range(3 * int'(at_least_one({4'd0, lamp_cfg.color_repeat_ticks})) + 2);
      if (len > 1400) len = $urandom_range(1, 400);
      for (int i = 0; i < len; i++) queue_tick($urandom_range(5) == 0, 1'b1);
    end else if (kind < 85) begin
      repeat ($urandom_range(1, 10)) queue_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
    end
    repeat ($urandom_range(1, 4)) queue_tick(1'b0, 1'b0);
  endfunction

  task automatic wait_drained();
    do @(posedge clk);
    while (button_q.size() != 0 || tick_valid || lamp_expect_q.size() != 0);
  endtask

  task automatic apb_write_reg(input reg_idx_t idx, input logic [31:0] value);
    logic [31:0] want;
    case (idx)
      REG_LONG_PRESS:   begin lamp_cfg.long_press_ticks   = value[15:0]; want = value & 32'hFFFF; end
      REG_RAMP_STEP:    begin lamp_cfg.ramp_step_ticks    = value[7:0];  want = value & 32'hFF;   end
      REG_FLASH:        begin lamp_cfg.flash_ticks        = value[9:0];  want = value & 32'h3FF;  end
      REG_COLOR_REPEAT: begin lamp_cfg.color_repeat_ticks = value[11:0]; want = value & 32'hFFF;  end
      REG_DEBOUNCE:     begin lamp_cfg.debounce_ticks     = value[7:0];  want = value & 32'hFF;   end
      REG_MIN_BRIGHT:   begin lamp_cfg.min_bright         = value[7:0];  want = value & 32'hFF;   end
      default:          begin lamp_cfg.max_bright         = value[7:0];  want = value & 32'hFF;   end
    endcase
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // read it back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      fail_count++;
      $display("%0t: register %s read back, expected %0h, got %0h", $time, idx.name(),
               want, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic load_settings(input logic [15:0] lp, input logic [7:0] rs,
                               input logic [9:0] fl, input logic [11:0] cr,
                               input logic [7:0] db, input logic [7:0] mn,
                               input logic [7:0] mx);
    wait_drained();
    apb_write_reg(REG_LONG_PRESS, {16'd0, lp});
    apb_write_reg(REG_RAMP_STEP, {24'd0, rs});
    apb_write_reg(REG_FLASH, {22'd0, fl});
    apb_write_reg(REG_COLOR_REPEAT, {20'd0, cr});
    apb_write_reg(REG_DEBOUNCE, {24'd0, db});
    apb_write_reg(REG_MIN_BRIGHT, {24'd0, mn});
    apb_write_reg(REG_MAX_BRIGHT, {24'd0, mx});
  endtask

  task automatic run_phase(input int items, input bit squeeze);
    int start;
    start = queued_items;
    while (queued_items - start < items / 2) add_gesture();
    if (squeeze) rx_hold_reqs++;
    // sender pauses here until every result is back
    wait_drained();
    while (queued_items - start < items) add_gesture();
    wait_drained();
  endtask

  // button items into the block
  always @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
    end else begin
      if (tick_valid && !tick_stall)
        lamp_expect_q.push_back('{lamp_step(on_bus.t), on_bus.known, on_bus.want});
      if (!tick_valid || !tick_stall) begin
        if (button_q.size() != 0 &&
            !(tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)) begin
          on_bus = button_q.pop_front();
          tick       <= on_bus.t;
          tick_valid <= 1'b1;
        end else begin
          tick_valid <= 1'b0;
        end
      end
    end
  end

  // lamp results out of the block
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (lamp_expect_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result %h", $time, result);
        end else begin
          head = lamp_expect_q.pop_front();
          compare_result(head.lamp, result);
          if (head.known) compare_result(head.want, result);
        end
      end
      if (rx_hold_reqs != rx_hold_seen) begin
        rx_hold_seen = rx_hold_reqs;
        rx_hold_left = HOLD_OFF;
      end
      if (rx_hold_left > 0) begin
        result_stall <= 1'b1;
        rx_hold_left--;
      end else begin
        result_stall <= rx_stall_pct != 0 && $urandom_range(99) < rx_stall_pct;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (tick_valid && !tick_stall) || (result_valid && !result_stall) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
      $display("tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int          k;
    logic [7:0]  mn, mx;
    button_item_t it;
    lamp_reset();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_REG) begin
        wait_drained();
        apb_write_reg(dir_tab[i].idx, dir_tab[i].value);
      end else begin
        it.t     = dir_tab[i].t;
        it.known = dir_tab[i].kind == ROW_CHECK;
        it.want  = dir_tab[i].want;
        button_q.push_back(it);
        queued_items++;
      end
    end
    wait_drained();

    for (k = 0; k < 10; k++) begin
      tx_idle_pct  = (k % 4 == 1) ? 45 : (k % 4 == 3) ? 35 : 0;
      rx_stall_pct = (k % 4 == 2) ? 45 : (k % 4 == 3) ? 35 : 0;
      case (k)
        0: load_settings(16'd3, 8'd1, 10'd2, 12'd2, 8'd1, 8'd20, 8'd30);
        1: load_settings(16'd1, 8'd1, 10'd0, 12'd1, 8'd0, 8'd0, 8'd255);
        2: load_settings(16'd5, 8'd2, 10'd3, 12'd3, 8'd2, 8'd255, 8'd0);
        3: load_settings(16'd65535, 8'd255, 10'd1023, 12'd4095, 8'd255, 8'd100, 8'd100);
        4: load_settings(16'd1, 8'd1, 10'd1023, 12'd2, 8'd0, 8'd126, 8'd130);
        // zero periods behave like one
        5: load_settings(16'd0, 8'd0, 10'd1, 12'd0, 8'd3, 8'd40, 8'd60);
        default: begin
          mn = 8'($urandom_range(255));
          if ($urandom_range(3) != 0)
            mx = (mn > 8'd235) ? 8'd255 : mn + 8'($urandom_range(2, 20));
          else mx = 8'($urandom_range(255));
          load_settings(16'($urandom_range(1, 8)), 8'($urandom_range(1, 4)),
                        10'($urandom_range(5)), 12'($urandom_range(1, 6)),
                        8'($urandom_range(4)), mn, mx);
        end
      endcase
      run_phase(PHASE_ITEMS, k % 4 == 0);
    end

    wait_drained();
    repeat (4) @(posedge clk);
    if (lamp_expect_q.size() != 0) begin
      fail_count++;
      $display("%0t: %0d results never arrived", $time, lamp_expect_q.size());
    end
    if (fail_count == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule
